// ===== rtl/bihp_pkg.sv =====
// shared types and constants for the bilevel image header parser
// parse phase codes, field kinds, error codes, id string bytes and the result record
// no dependencies
package bihp_pkg;

   typedef enum logic [3:0] {
      PH_ID        = 4'd0,
      PH_FLAGS     = 4'd1,
      PH_PAGES     = 4'd2,
      PH_SEGNUM    = 4'd3,
      PH_SEGFLAGS  = 4'd4,
      PH_REFCOUNT  = 4'd5,
      PH_LONGCOUNT = 4'd6,
      PH_SKIP      = 4'd7,
      PH_REFNUM    = 4'd8,
      PH_PAGEASSOC = 4'd9,
      PH_DATALEN   = 4'd10
   } phase_type;

   typedef enum logic [2:0] {
      KIND_ORG       = 3'd0,
      KIND_PAGES     = 3'd1,
      KIND_SEGNUM    = 3'd2,
      KIND_TYPE      = 3'd3,
      KIND_REFCOUNT  = 3'd4,
      KIND_REFNUM    = 3'd5,
      KIND_PAGEASSOC = 3'd6,
      KIND_DATALEN   = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_BAD_ID   = 2'd1,
      ERR_BAD_FLAG = 2'd2,
      ERR_BAD_REFS = 2'd3
   } err_type;

   // referred-to count codes in the short form
   localparam logic [2:0] REFS_BAD_LO = 3'd5;
   localparam logic [2:0] REFS_BAD_HI = 3'd6;
   localparam logic [2:0] REFS_LONG   = 3'd7;

   // segment number limits for 1- and 2-byte referred-to numbers
   localparam logic [31:0] SEG_LIMIT_NARROW = 32'd256;
   localparam logic [31:0] SEG_LIMIT_MID    = 32'd65536;

   // value that marks an unknown data length
   localparam logic [31:0] LEN_UNKNOWN = 32'hFFFF_FFFF;

   typedef struct packed {
      kind_type    field_kind;
      logic [31:0] field_value;
      logic        length_known;
      err_type     error_code;
      logic        header_done;
   } rec_type;

   // file id string, byte by byte
   function automatic logic [7:0] magic_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0: b = 8'h97;
         3'd1: b = 8'h4A;
         3'd2: b = 8'h42;
         3'd3: b = 8'h32;
         3'd4: b = 8'h0D;
         3'd5: b = 8'h0A;
         3'd6: b = 8'h1A;
         3'd7: b = 8'h0A;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/bihp_parser.sv =====
// front end: takes one stream byte per transaction and walks the header phases
// emits at most one result record per byte; uses bihp_pkg
module bihp_parser
   import bihp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       first_of_file,
   output logic       rec_valid,
   output rec_type    rec
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  byte_index_ff, byte_index_in;
   logic [31:0] gather_ff, gather_in;
   logic [31:0] seg_kept_ff, seg_kept_in;
   logic        wide_pa_ff, wide_pa_in;
   logic [28:0] refs_left_ff, refs_left_in;
   logic [26:0] skip_left_ff, skip_left_in;
   logic        halted_ff, halted_in;

   always_comb begin
      phase_type   cur_phase;
      logic [2:0]  cur_idx;
      logic [31:0] cur_gather;
      logic [31:0] cur_seg;
      logic        cur_wide;
      logic [28:0] cur_refs;
      logic [26:0] cur_skip;
      logic        cur_halt;
      logic [31:0] sh_word;
      logic [2:0]  sh_idx;
      logic [2:0]  need;
      logic        got_all;
      logic [2:0]  cnt;
      logic [28:0] long_cnt;
      logic [29:0] skip_sum;
      logic [26:0] skip_dec;
      logic [28:0] refs_dec;

      cur_phase  = phase_ff;
      cur_idx    = byte_index_ff;
      cur_gather = gather_ff;
      cur_seg    = seg_kept_ff;
      cur_wide   = wide_pa_ff;
      cur_refs   = refs_left_ff;
      cur_skip   = skip_left_ff;
      cur_halt   = halted_ff;
      // first byte of a file restarts from the id string
      if (first_of_file) begin
         cur_phase  = PH_ID;
         cur_idx    = 3'd0;
         cur_gather = 32'd0;
         cur_seg    = 32'd0;
         cur_wide   = 1'b0;
         cur_refs   = 29'd0;
         cur_skip   = 27'd0;
         cur_halt   = 1'b0;
      end

      phase_in      = cur_phase;
      byte_index_in = cur_idx;
      gather_in     = cur_gather;
      seg_kept_in   = cur_seg;
      wide_pa_in    = cur_wide;
      refs_left_in  = cur_refs;
      skip_left_in  = cur_skip;
      halted_in     = cur_halt;
      rec_valid     = 1'b0;
      rec           = '0;

      // big-endian byte gather shared by all multi-byte fields
      sh_word  = {((cur_idx == 3'd0) ? 24'd0 : cur_gather[23:0]), in_byte};
      sh_idx   = cur_idx + 3'd1;
      need     = 3'd4;
      cnt      = in_byte[7:5];
      long_cnt = sh_word[28:0];
      skip_sum = {1'b0, long_cnt} + 30'd8;
      skip_dec = (cur_skip != 27'd0) ? (cur_skip - 27'd1) : cur_skip;
      refs_dec = (cur_refs != 29'd0) ? (cur_refs - 29'd1) : cur_refs;

      if (cur_phase == PH_REFNUM) begin
         if (cur_seg <= SEG_LIMIT_NARROW) begin
            need = 3'd1;
         end else if (cur_seg <= SEG_LIMIT_MID) begin
            need = 3'd2;
         end
      end else if (cur_phase == PH_PAGEASSOC) begin
         need = cur_wide ? 3'd4 : 3'd1;
      end
      got_all = (sh_idx >= need);

      if (!cur_halt) begin
         unique case (cur_phase)
            PH_ID: begin
               if (in_byte != magic_byte(cur_idx)) begin
                  halted_in           = 1'b1;
                  rec_valid           = 1'b1;
                  rec.error_code      = ERR_BAD_ID;
               end else begin
                  byte_index_in = sh_idx;
                  if (sh_idx == 3'd0) begin
                     phase_in = PH_FLAGS;
                  end
               end
            end
            PH_FLAGS: begin
               if (in_byte[7:4] != 4'd0) begin
                  halted_in      = 1'b1;
                  rec_valid      = 1'b1;
                  rec.error_code = ERR_BAD_FLAG;
               end else begin
                  byte_index_in   = 3'd0;
                  phase_in        = in_byte[1] ? PH_SEGNUM : PH_PAGES;
                  rec_valid       = 1'b1;
                  rec.field_kind  = KIND_ORG;
                  rec.field_value = {31'd0, ~in_byte[0]};
               end
            end
            PH_PAGES, PH_SEGNUM, PH_REFNUM, PH_PAGEASSOC, PH_DATALEN, PH_LONGCOUNT: begin
               gather_in     = sh_word;
               byte_index_in = got_all ? 3'd0 : sh_idx;
               if (got_all) begin
                  rec_valid       = 1'b1;
                  rec.field_value = sh_word;
                  unique case (cur_phase)
                     PH_PAGES: begin
                        phase_in       = PH_SEGNUM;
                        rec.field_kind = KIND_PAGES;
                     end
                     PH_SEGNUM: begin
                        seg_kept_in    = sh_word;
                        phase_in       = PH_SEGFLAGS;
                        rec.field_kind = KIND_SEGNUM;
                     end
                     PH_LONGCOUNT: begin
                        refs_left_in    = long_cnt;
                        skip_left_in    = skip_sum[29:3];
                        phase_in        = PH_SKIP;
                        rec.field_kind  = KIND_REFCOUNT;
                        rec.field_value = {3'd0, long_cnt};
                     end
                     PH_REFNUM: begin
                        refs_left_in   = refs_dec;
                        rec.field_kind = KIND_REFNUM;
                        if (refs_dec == 29'd0) begin
                           phase_in = PH_PAGEASSOC;
                        end
                     end
                     PH_PAGEASSOC: begin
                        phase_in       = PH_DATALEN;
                        rec.field_kind = KIND_PAGEASSOC;
                     end
                     default: begin
                        // data length ends the header
                        halted_in        = 1'b1;
                        rec.field_kind   = KIND_DATALEN;
                        rec.length_known = (sh_word != LEN_UNKNOWN);
                        rec.header_done  = 1'b1;
                     end
                  endcase
               end
            end
            PH_SEGFLAGS: begin
               wide_pa_in      = in_byte[6];
               phase_in        = PH_REFCOUNT;
               rec_valid       = 1'b1;
               rec.field_kind  = KIND_TYPE;
               rec.field_value = {26'd0, in_byte[5:0]};
            end
            PH_REFCOUNT: begin
               if (cnt == REFS_BAD_LO || cnt == REFS_BAD_HI) begin
                  halted_in      = 1'b1;
                  rec_valid      = 1'b1;
                  rec.error_code = ERR_BAD_REFS;
               end else if (cnt == REFS_LONG) begin
                  gather_in     = {27'd0, in_byte[4:0]};
                  byte_index_in = 3'd1;
                  phase_in      = PH_LONGCOUNT;
               end else begin
                  refs_left_in    = {26'd0, cnt};
                  byte_index_in   = 3'd0;
                  phase_in        = (cnt != 3'd0) ? PH_REFNUM : PH_PAGEASSOC;
                  rec_valid       = 1'b1;
                  rec.field_kind  = KIND_REFCOUNT;
                  rec.field_value = {29'd0, cnt};
               end
            end
            PH_SKIP: begin
               skip_left_in = skip_dec;
               if (skip_dec == 27'd0) begin
                  byte_index_in = 3'd0;
                  phase_in      = (cur_refs != 29'd0) ? PH_REFNUM : PH_PAGEASSOC;
               end
            end
            default: begin
               // unused phase codes behave as halted
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_ID;
         byte_index_ff <= 3'd0;
         gather_ff     <= 32'd0;
         seg_kept_ff   <= 32'd0;
         wide_pa_ff    <= 1'b0;
         refs_left_ff  <= 29'd0;
         skip_left_ff  <= 27'd0;
         halted_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         byte_index_ff <= byte_index_in;
         gather_ff     <= gather_in;
         seg_kept_ff   <= seg_kept_in;
         wide_pa_ff    <= wide_pa_in;
         refs_left_ff  <= refs_left_in;
         skip_left_ff  <= skip_left_in;
         halted_ff     <= halted_in;
      end
   end

`ifndef SYNTH
   // a halted parser only wakes on a first-of-file byte
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      (halted_ff && !first_of_file) |-> !rec_valid)
      else $error("result produced while halted");

   // an error result always halts the parse
   a_err_halts: assert property (@(posedge clock) disable iff (reset)
      (accept && rec_valid && rec.error_code != ERR_NONE) |=> halted_ff)
      else $error("error result did not halt");

   // header done only comes with the data length field
   a_done_kind: assert property (@(posedge clock) disable iff (reset)
      (rec_valid && rec.header_done) |-> (rec.field_kind == KIND_DATALEN))
      else $error("header done on wrong field");
`endif

endmodule

// ===== rtl/bihp_queue.sv =====
// back end: short result queue that decouples the parser from the result consumer
// register array with wrapping pointers and an occupancy count; uses bihp_pkg
module bihp_queue
   import bihp_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  rec_type wr_rec,
   input  logic    rd_en,
   output rec_type rd_rec,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   rec_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full   = (count_ff == CNT_FULL);
   assign empty  = (count_ff == '0);
   assign rd_rec = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : (wr_ptr_ff + 1'b1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : (rd_ptr_ff + 1'b1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (!full || rd_en))
      else $error("write into full queue");

   a_write_shows: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !rd_en) |=> !empty)
      else $error("queue empty after write");
`endif

endmodule

// ===== rtl/bilevel_image_header_parser.sv =====
// top level of the bilevel image header parser
// instantiates bihp_parser (front end) and bihp_queue (result queue); uses bihp_pkg
//
// one byte of a bilevel image file is pushed per transaction, at up to one byte
// every clock cycle while req_full is low. the front end checks the 8-byte id
// string and the file header flags, then walks the first segment header and
// produces at most one result record per byte in the same cycle the byte is
// taken: organization, page count (when flags bit 1 is clear), segment number,
// type, referred-to count, each referred-to number, page association and data
// length. an error reports its code and halts the parse; after the data length
// (header_done high) the parse also halts. either way bytes are swallowed
// without results until a byte with first_of_file high, which restarts the
// parse at id byte 0. results wait in a DEPTH-entry queue and are popped in
// order at up to one per cycle, so with pop held high the sustained rate is
// one byte per cycle; a result is registered in the queue before it can be
// popped. full goes high only while the queue holds DEPTH unpopped results.
module bilevel_image_header_parser
   import bihp_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // byte stream, one byte per transaction
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_first_of_file,
   // decoded fields, oldest first
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_field_kind,
   output logic [31:0] rsp_field_value,
   output logic        rsp_length_known,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_header_done
);

   logic    byte_accept;
   logic    rsp_accept;
   logic    rec_valid;
   rec_type rec;
   rec_type head_rec;

   // a byte is taken only when the queue has room for the result it may make
   assign byte_accept = req_push && !req_full;
   assign rsp_accept  = rsp_pop && !rsp_empty;

   bihp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (byte_accept),
      .in_byte       (req_in_byte),
      .first_of_file (req_first_of_file),
      .rec_valid     (rec_valid),
      .rec           (rec)
   );

   bihp_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (byte_accept && rec_valid),
      .wr_rec (rec),
      .rd_en  (rsp_accept),
      .rd_rec (head_rec),
      .full   (req_full),
      .empty  (rsp_empty)
   );

   // unpack the head of the queue onto the result ports
   assign rsp_field_kind   = head_rec.field_kind;
   assign rsp_field_value  = head_rec.field_value;
   assign rsp_length_known = head_rec.length_known;
   assign rsp_error_code   = head_rec.error_code;
   assign rsp_header_done  = head_rec.header_done;

endmodule

// ===== test/bilevel_image_header_parser_tb.sv =====
// testbench for the bilevel image header parser: drives byte streams and checks decoded fields
// depends on bihp_pkg and bilevel_image_header_parser from rtl/
module bilevel_image_header_parser_tb;
   import bihp_pkg::*;

   // run control
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BYTES = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int NO_POS       = 1 << 30;

   // file format constants
   localparam logic [63:0] FILE_MAGIC    = 64'h974A_4232_0D0A_1A0A;
   localparam logic [7:0]  FLAG_RSVD     = 8'hF0;
   localparam logic [31:0] LONG_CNT_MASK = 32'h1FFF_FFFF;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_in_byte;
   logic        req_first_of_file;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [2:0]  rsp_field_kind;
   logic [31:0] rsp_field_value;
   logic        rsp_length_known;
   logic [1:0]  rsp_error_code;
   logic        rsp_header_done;

   bilevel_image_header_parser u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_in_byte       (req_in_byte),
      .req_first_of_file (req_first_of_file),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_field_kind    (rsp_field_kind),
      .rsp_field_value   (rsp_field_value),
      .rsp_length_known  (rsp_length_known),
      .rsp_error_code    (rsp_error_code),
      .rsp_header_done   (rsp_header_done)
   );

   // decoded fields still owed by the block, oldest first
   rec_type pending_fields[$];
   rec_type want_rec;

   int fail_count  = 0;
   int cycle_count = 0;
   int n_sent      = 0;
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;

   // file builder state: position in the file, truncation and corruption points
   int   file_pos;
   logic file_mark;
   int   cut_at     = NO_POS;
   int   corrupt_at = NO_POS;

   // parser copy kept by the testbench
   phase_type   cur_phase;
   logic [2:0]  byte_idx;
   logic [31:0] gather_reg;
   logic [31:0] seg_num;
   logic        pages_on;
   logic        wide_assoc;
   logic [28:0] refs_left;
   logic [26:0] skip_left;
   logic        parse_halted;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // field decoder
   // ------------------------------------------------------------------

   function automatic void restart_parser();
      cur_phase    = PH_ID;
      byte_idx     = 3'd0;
      gather_reg   = 32'd0;
      seg_num      = 32'd0;
      pages_on     = 1'b0;
      wide_assoc   = 1'b0;
      refs_left    = 29'd0;
      skip_left    = 27'd0;
      parse_halted = 1'b0;
   endfunction

   // shifts one byte into the big-endian gather register, true once need bytes are in
   function automatic bit gather_byte(input logic [7:0] b, input int need);
      if (byte_idx == 3'd0)
         gather_reg = 32'd0;
      gather_reg = {gather_reg[23:0], b};
      byte_idx = byte_idx + 3'd1;
      if (int'(byte_idx) >= need) begin
         byte_idx = 3'd0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // advances the parser by one byte; returns 1 when the byte yields a field
   function automatic bit decode_byte(input logic [7:0] b, input logic mark,
                                      output rec_type rec);
      bit          got;
      logic [2:0]  cnt3;
      logic [31:0] cnt;
      logic [31:0] skip_full;
      int          need;
      got = 1'b0;
      rec.field_kind   = KIND_ORG;
      rec.field_value  = 32'd0;
      rec.length_known = 1'b0;
      rec.error_code   = ERR_NONE;
      rec.header_done  = 1'b0;
      if (mark)
         restart_parser();
      if (parse_halted)
         return 1'b0;
      case (cur_phase)
         PH_ID: begin
            if (b != FILE_MAGIC[8 * (7 - int'(byte_idx)) +: 8]) begin
               got = 1'b1;
               rec.error_code = ERR_BAD_ID;
               parse_halted = 1'b1;
            end else begin
               byte_idx = byte_idx + 3'd1;
               if (byte_idx == 3'd0)
                  cur_phase = PH_FLAGS;
            end
         end
         PH_FLAGS: begin
            got = 1'b1;
            if ((b & FLAG_RSVD) != 8'd0) begin
               rec.error_code = ERR_BAD_FLAG;
               parse_halted = 1'b1;
            end else begin
               // bit 1 clear means a page count follows; bit 0 clear is random access
               pages_on = ~b[1];
               byte_idx = 3'd0;
               cur_phase = pages_on ? PH_PAGES : PH_SEGNUM;
               rec.field_value = {31'd0, ~b[0]};
            end
         end
         PH_PAGES: begin
            if (gather_byte(b, 4)) begin
               got = 1'b1;
               cur_phase = PH_SEGNUM;
               rec.field_kind  = KIND_PAGES;
               rec.field_value = gather_reg;
            end
         end
         PH_SEGNUM: begin
            if (gather_byte(b, 4)) begin
               got = 1'b1;
               seg_num = gather_reg;
               cur_phase = PH_SEGFLAGS;
               rec.field_kind  = KIND_SEGNUM;
               rec.field_value = gather_reg;
            end
         end
         PH_SEGFLAGS: begin
            got = 1'b1;
            wide_assoc = b[6];
            cur_phase = PH_REFCOUNT;
            rec.field_kind  = KIND_TYPE;
            rec.field_value = {26'd0, b[5:0]};
         end
         PH_REFCOUNT: begin
            cnt3 = b[7:5];
            if (cnt3 == REFS_BAD_LO || cnt3 == REFS_BAD_HI) begin
               got = 1'b1;
               rec.error_code = ERR_BAD_REFS;
               parse_halted = 1'b1;
            end else if (cnt3 == REFS_LONG) begin
               // long form: low 5 bits are the top of a 29-bit count
               gather_reg = {27'd0, b[4:0]};
               byte_idx = 3'd1;
               cur_phase = PH_LONGCOUNT;
            end else begin
               got = 1'b1;
               refs_left = {26'd0, cnt3};
               byte_idx = 3'd0;
               cur_phase = (cnt3 != 3'd0) ? PH_REFNUM : PH_PAGEASSOC;
               rec.field_kind  = KIND_REFCOUNT;
               rec.field_value = {29'd0, cnt3};
            end
         end
         PH_LONGCOUNT: begin
            if (gather_byte(b, 4)) begin
               got = 1'b1;
               cnt = gather_reg & LONG_CNT_MASK;
               refs_left = cnt[28:0];
               // retention bytes: ceil((count + 1) / 8), never zero
               skip_full = (cnt + 32'd8) >> 3;
               skip_left = skip_full[26:0];
               cur_phase = PH_SKIP;
               rec.field_kind  = KIND_REFCOUNT;
               rec.field_value = cnt;
            end
         end
         PH_SKIP: begin
            if (skip_left != 27'd0)
               skip_left = skip_left - 27'd1;
            if (skip_left == 27'd0) begin
               byte_idx = 3'd0;
               cur_phase = (refs_left != 29'd0) ? PH_REFNUM : PH_PAGEASSOC;
            end
         end
         PH_REFNUM: begin
            // referred-to numbers widen with the segment number
            need = (seg_num <= SEG_LIMIT_NARROW) ? 1 : (seg_num <= SEG_LIMIT_MID) ? 2 : 4;
            if (gather_byte(b, need)) begin
               got = 1'b1;
               if (refs_left != 29'd0)
                  refs_left = refs_left - 29'd1;
               if (refs_left == 29'd0)
                  cur_phase = PH_PAGEASSOC;
               rec.field_kind  = KIND_REFNUM;
               rec.field_value = gather_reg;
            end
         end
         PH_PAGEASSOC: begin
            if (gather_byte(b, wide_assoc ? 4 : 1)) begin
               got = 1'b1;
               cur_phase = PH_DATALEN;
               rec.field_kind  = KIND_PAGEASSOC;
               rec.field_value = gather_reg;
            end
         end
         PH_DATALEN: begin
            if (gather_byte(b, 4)) begin
               got = 1'b1;
               parse_halted = 1'b1;
               rec.field_kind   = KIND_DATALEN;
               rec.field_value  = gather_reg;
               rec.length_known = (gather_reg != LEN_UNKNOWN);
               rec.header_done  = 1'b1;
            end
         end
         default: ;
      endcase
      return got;
   endfunction

   // ------------------------------------------------------------------
   // byte sender: drives at the falling edge, takes the transaction at the rising edge
   // ------------------------------------------------------------------

   task automatic send_byte(input logic [7:0] b, input logic mark);
      rec_type rec;
      @(negedge clock);
      // random sender gaps
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push          = 1'b1;
      req_in_byte       = b;
      req_first_of_file = mark;
      @(posedge clock);
      // hold the byte while the result queue is full
      while (req_full)
         @(posedge clock);
      if (decode_byte(b, mark, rec))
         pending_fields.push_back(rec);
      n_sent++;
   endtask

   // sender holds off until every owed field has been popped
   task automatic wait_drained();
      @(negedge clock);
      req_push = 1'b0;
      while (pending_fields.size() != 0)
         @(negedge clock);
   endtask

   // one byte of a file, subject to truncation and corruption
   task automatic file_byte(input logic [7:0] b);
      logic [7:0] v;
      v = b;
      if (file_pos == corrupt_at)
         v = 8'($urandom_range(0, 255));
      if (file_pos < cut_at)
         send_byte(v, (file_pos == 0) ? file_mark : 1'b0);
      file_pos++;
   endtask

   task automatic put_word(input logic [31:0] w, input int nbytes);
      for (int i = nbytes - 1; i >= 0; i--)
         file_byte(w[8 * i +: 8]);
   endtask

   // id string, file header and first segment header with random retention and refs
   task automatic send_file(input logic mark, input logic [7:0] hdr_flags,
                            input logic [31:0] pages, input logic [31:0] segnum,
                            input logic [7:0] seg_flags, input bit long_form,
                            input int unsigned count, input logic [31:0] page_assoc,
                            input logic [31:0] data_len);
      int         ref_size;
      logic [4:0] retain;
      logic [28:0] cnt29;
      file_pos  = 0;
      file_mark = mark;
      for (int i = 0; i < 8; i++)
         file_byte(FILE_MAGIC[8 * (7 - i) +: 8]);
      file_byte(hdr_flags);
      if (!hdr_flags[1])
         put_word(pages, 4);
      put_word(segnum, 4);
      file_byte(seg_flags);
      if (long_form) begin
         cnt29 = count[28:0];
         put_word({REFS_LONG, cnt29}, 4);
         repeat ((count + 8) / 8)
            file_byte(8'($urandom_range(0, 255)));
      end else begin
         retain = 5'($urandom_range(0, 31));
         file_byte({count[2:0], retain});
      end
      ref_size = (segnum <= SEG_LIMIT_NARROW) ? 1 : (segnum <= SEG_LIMIT_MID) ? 2 : 4;
      repeat (count)
         put_word($urandom, ref_size);
      put_word(page_assoc, seg_flags[6] ? 4 : 1);
      put_word(data_len, 4);
   endtask

   // ------------------------------------------------------------------
   // result side: random pop stalls and the field checker
   // ------------------------------------------------------------------

   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         rsp_pop = !reset && ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         fail_count++;
         $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
      end
   endtask

   // each popped transaction is matched against the oldest owed field
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_fields.size() == 0) begin
            fail_count++;
            $error("unexpected transaction: field_kind %0d field_value 0x%0h",
                   rsp_field_kind, rsp_field_value);
         end else begin
            want_rec = pending_fields.pop_front();
            check_field("field_kind", 32'(want_rec.field_kind), 32'(rsp_field_kind));
            check_field("field_value", want_rec.field_value, rsp_field_value);
            check_field("length_known", 32'(want_rec.length_known), 32'(rsp_length_known));
            check_field("error_code", 32'(want_rec.error_code), 32'(rsp_error_code));
            check_field("header_done", 32'(want_rec.header_done), 32'(rsp_header_done));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // directed tests
   // ------------------------------------------------------------------

   // parse starts at id byte 0 with no first mark; all-ones pages and page assoc, unknown length
   task automatic test_reset_stream();
      send_file(1'b0, 8'h01, 32'hFFFF_FFFF, 32'd0, 8'hFF, 1'b0, 4,
                32'hFFFF_FFFF, LEN_UNKNOWN);
      // finished parse swallows unmarked bytes
      send_byte(8'h97, 1'b0);
      send_byte(8'hFF, 1'b0);
   endtask

   // id mismatch at the first byte, in the middle and at the last byte
   task automatic test_id_errors();
      send_byte(8'h00, 1'b1);
      send_byte(8'h4A, 1'b0);
      send_byte(8'h97, 1'b1);
      send_byte(8'h4A, 1'b0);
      send_byte(8'h43, 1'b0);
      for (int i = 0; i < 7; i++)
         send_byte(FILE_MAGIC[8 * (7 - i) +: 8], i == 0);
      send_byte(8'h0B, 1'b0);
   endtask

   // reserved header flag bits, and the ignored flag bits 2 and 3
   task automatic test_flag_errors();
      send_file(1'b1, 8'hF0, 32'd0, 32'd0, 8'h00, 1'b0, 0, 32'd0, 32'd0);
      send_file(1'b1, 8'h10, 32'd0, 32'd0, 8'h00, 1'b0, 0, 32'd0, 32'd0);
      send_file(1'b1, 8'h0E, 32'd0, SEG_LIMIT_NARROW, 8'h00, 1'b0, 1, 32'd0, 32'd0);
   endtask

   // short-form referred-to counts 5 and 6 are rejected
   task automatic test_refcount_errors();
      send_file(1'b1, 8'h02, 32'd0, 32'd257, 8'h40, 1'b0, 5, 32'd1, 32'd1);
      send_file(1'b1, 8'h00, 32'd7, 32'd257, 8'h80, 1'b0, 6, 32'd1, 32'd1);
   endtask

   // long count of zero still skips a retention byte; 2- and 4-byte ref numbers
   task automatic test_long_counts();
      send_file(1'b1, 8'h03, 32'd0, SEG_LIMIT_MID, 8'h00, 1'b1, 0, 32'h7F,
                32'hFFFF_FFFE);
      send_file(1'b1, 8'h00, 32'd0, SEG_LIMIT_MID, 8'h41, 1'b1, 7, 32'h8000_0001, 32'd0);
      send_file(1'b1, 8'h00, 32'd3, SEG_LIMIT_MID + 32'd1, 8'h40, 1'b1, 8,
                32'h0, 32'd0);
   endtask

   // a new first mark in the middle of a header restarts the parse
   task automatic test_restart_mid();
      cut_at = 14;
      send_file(1'b1, 8'h01, 32'h1234_5678, 32'd300, 8'h00, 1'b0, 2, 32'd5, 32'd9);
      cut_at = NO_POS;
      send_file(1'b1, 8'h02, 32'd0, 32'd257, 8'h00, 1'b0, 3, 32'd5, 32'd9);
   endtask

   // ------------------------------------------------------------------
   // random streams: mostly well-formed files, some corrupted, truncated or noise
   // ------------------------------------------------------------------

   task automatic test_random_streams();
      int          start;
      int          stage;
      int          last_stage;
      int          sel;
      logic [31:0] segnum;
      int unsigned count;
      bit          long_form;
      start = n_sent;
      last_stage = -1;
      while (n_sent - start < RANDOM_BYTES) begin
         // idling phases, with a full drain at each change
         stage = (n_sent - start) * 4 / RANDOM_BYTES;
         if (stage != last_stage) begin
            wait_drained();
            case (stage)
               0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
               1: begin tx_idle_pct = 57; rx_stall_pct = 0;  end
               2: begin tx_idle_pct = 0;  rx_stall_pct = 57; end
               default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
            endcase
            last_stage = stage;
         end
         sel = $urandom_range(0, 99);
         if (sel >= 95) begin
            // noise with the odd first mark
            repeat ($urandom_range(1, 8))
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end else begin
            // segment number around the ref number width boundaries
            case ($urandom_range(0, 5))
               0: segnum = $urandom_range(0, 256);
               1: segnum = SEG_LIMIT_NARROW + $urandom_range(0, 1);
               2: segnum = $urandom_range(257, 65536);
               3: segnum = SEG_LIMIT_MID + $urandom_range(0, 1);
               4: segnum = $urandom;
               default: segnum = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            endcase
            long_form = ($urandom_range(0, 4) == 0);
            count = long_form ? $urandom_range(0, 17) : $urandom_range(0, 4);
            if (sel >= 87)
               cut_at = $urandom_range(1, 30);
            else if (sel >= 75)
               corrupt_at = $urandom_range(0, 30);
            send_file($urandom_range(0, 9) != 0, 8'($urandom_range(0, 15)), $urandom,
                      segnum, 8'($urandom_range(0, 255)), long_form, count, $urandom,
                      ($urandom_range(0, 5) == 0) ? LEN_UNKNOWN : $urandom);
            cut_at = NO_POS;
            corrupt_at = NO_POS;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------

   initial begin
      reset             = 1'b1;
      req_push          = 1'b0;
      req_in_byte       = 8'd0;
      req_first_of_file = 1'b0;
      restart_parser();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_stream();
      test_id_errors();
      test_flag_errors();
      test_refcount_errors();
      test_long_counts();
      test_restart_mid();
      test_random_streams();

      // stop sending, let the receiver drain everything, then wait out the quiet drain period
      @(negedge clock);
      req_push = 1'b0;
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      while (pending_fields.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bihp_pkg.sv
rtl/bihp_parser.sv
rtl/bihp_queue.sv
rtl/bilevel_image_header_parser.sv
test/bilevel_image_header_parser_tb.sv
